// ----- rtl/tsd_pkg.sv -----
package tsd_pkg;

    localparam int DEF_NODE_COUNT    = 1024;
    localparam int DEF_ALPHABET_SIZE = 26;

    // letter index width, enough for an alphabet of up to 32 letters
    localparam int SYM_W = 5;

    localparam logic [7:0] FIRST_LETTER = 8'h61;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_EXACT  = 2'd1;
    localparam logic [1:0] MODE_PREFIX = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BADCHAR = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LINK,
        S_MARK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;   // sweep memories, one entry per cycle
        logic accept;  // take the input item, issue the link read
        logic step;    // use the link read: follow, allocate or miss
        logic mark;    // end-mark read or write at the current node
        logic finish;  // load the result, return walk to the root
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic in_go;      // input item walks one link
        logic in_last;
        logic item_last;  // registered last flag of the item in work
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/trie_string_dictionary.sv -----
// channel  | direction | handshake         | payload
// ---------+-----------+-------------------+----------------------------------------
// input    | in        | i_valid / o_ready | i_mode, i_letter, i_has_letter, i_last
// result   | out       | o_valid / i_ready | o_found, o_status
//
// A letter item that walks one link reads the link memory in S_IDLE, then follows,
// allocates or misses in S_LINK. An item that does not walk needs only S_IDLE.
// A last item then uses S_MARK for the end-mark access, S_DONE for the result load.
// After reset the link and end-mark memories are swept one entry per cycle,
// all NODE_COUNT * ALPHABET_SIZE link entries, with o_ready low.
// The result sits in an output register; input items are taken while it waits.
module trie_string_dictionary
    import tsd_pkg::*;
#(
    parameter int NODE_COUNT    = DEF_NODE_COUNT,
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_letter,
    input  logic       i_has_letter,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_found,
    output logic [1:0] o_status
);

    t_cmd cmd;
    t_sts sts;

    tsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tsd_datapath #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_mode),
        .i_letter     (i_letter),
        .i_has_letter (i_has_letter),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_found      (o_found),
        .o_status     (o_status)
    );

endmodule

// ----- rtl/tsd_ctrl.sv -----
module tsd_ctrl
    import tsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.in_go) begin
                        n_state = S_LINK;
                    end else if (i_sts.in_last) begin
                        n_state = S_MARK;
                    end
                end
            end
            S_LINK: begin
                o_cmd.step = 1'b1;
                n_state    = i_sts.item_last ? S_MARK : S_IDLE;
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ----- rtl/tsd_datapath.sv -----
module tsd_datapath
    import tsd_pkg::*;
#(
    parameter int NODE_COUNT    = DEF_NODE_COUNT,
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_letter,
    input  logic       i_has_letter,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_found,
    output logic [1:0] o_status
);

    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int FREE_W     = $clog2(NODE_COUNT + 1);
    localparam int LINK_DEPTH = NODE_COUNT * ALPHABET_SIZE;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);

    logic [NODE_W-1:0] r_link_mem [LINK_DEPTH];
    logic              r_mark_mem [NODE_COUNT];

    logic [LINK_AW-1:0] r_clr_cnt;
    logic [NODE_W-1:0]  r_cur;
    logic [LINK_AW-1:0] r_base;     // r_cur * ALPHABET_SIZE
    logic [FREE_W-1:0]  r_next_free;
    logic               r_missed;
    logic [1:0]         r_err;
    logic [1:0]         r_mode;
    logic               r_last;
    logic [LINK_AW-1:0] r_addr;
    logic [NODE_W-1:0]  r_link_q;
    logic               r_mark_q;
    logic               r_out_valid;
    logic               r_out_found;
    logic [1:0]         r_out_status;

    logic [7:0]         sym8;
    logic [SYM_W-1:0]   sym;
    logic               letter_ok;
    logic               walk;
    logic [1:0]         mode_n;
    logic [LINK_AW-1:0] rd_addr;

    logic               link_empty;
    logic               pool_full;
    logic               alloc;
    logic [NODE_W-1:0]  n_cur;
    logic               cur_moves;

    logic               link_we;
    logic [LINK_AW-1:0] link_waddr;
    logic [NODE_W-1:0]  link_wdata;
    logic               mark_we;
    logic [NODE_W-1:0]  mark_waddr;
    logic               mark_wdata;
    logic               found;

    // ---- input item decode
    assign sym8      = i_letter - FIRST_LETTER;
    assign sym       = sym8[SYM_W-1:0];
    assign letter_ok = (i_letter >= FIRST_LETTER) && (sym8 < 8'(ALPHABET_SIZE));
    assign walk      = i_has_letter && (r_err == ST_OK) && !r_missed;
    assign mode_n    = (i_mode == MODE_INSERT || i_mode == MODE_EXACT) ? i_mode : MODE_PREFIX;
    assign rd_addr   = r_base + LINK_AW'(sym);

    // ---- link step
    assign link_empty = (r_link_q == '0);
    assign pool_full  = (r_next_free == FREE_W'(NODE_COUNT));
    assign alloc      = i_cmd.step && (r_mode == MODE_INSERT) && link_empty && !pool_full;
    assign n_cur      = alloc ? r_next_free[NODE_W-1:0] : r_link_q;
    assign cur_moves  = i_cmd.step && (alloc || !link_empty);

    // ---- memory write ports
    assign link_we    = i_cmd.clear || alloc;
    assign link_waddr = i_cmd.clear ? r_clr_cnt : r_addr;
    assign link_wdata = i_cmd.clear ? '0 : r_next_free[NODE_W-1:0];

    assign mark_we    = (i_cmd.clear && (r_clr_cnt < LINK_AW'(NODE_COUNT)))
                     || (i_cmd.mark && (r_mode == MODE_INSERT)
                         && (r_err == ST_OK) && !r_missed);
    assign mark_waddr = i_cmd.clear ? r_clr_cnt[NODE_W-1:0] : r_cur;
    assign mark_wdata = !i_cmd.clear;

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_waddr] <= link_wdata;
        end
        if (i_cmd.accept) begin
            r_link_q <= r_link_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_mark_mem[mark_waddr] <= mark_wdata;
        end
        if (i_cmd.mark) begin
            r_mark_q <= r_mark_mem[r_cur];
        end
    end

    // ---- result
    always_comb begin
        found = 1'b0;
        if (r_err == ST_OK && !r_missed) begin
            case (r_mode)
                MODE_EXACT: found = r_mark_q;
                default:    found = 1'b1;
            endcase
        end
    end

    // ---- walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_cur       <= '0;
            r_base      <= '0;
            r_next_free <= FREE_W'(1);
            r_missed    <= 1'b0;
            r_err       <= ST_OK;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.accept) begin
                r_last <= i_last;
                if (walk && !letter_ok) begin
                    r_err <= ST_BADCHAR;
                end
            end
            if (i_cmd.step) begin
                if (r_mode == MODE_INSERT) begin
                    if (link_empty && pool_full) begin
                        r_err <= ST_FULL;
                    end
                end else if (link_empty) begin
                    r_missed <= 1'b1;
                end
                if (alloc) begin
                    r_next_free <= r_next_free + 1'b1;
                end
                if (cur_moves) begin
                    r_cur  <= n_cur;
                    r_base <= LINK_AW'(n_cur) * LINK_AW'(ALPHABET_SIZE);
                end
            end
            if (i_cmd.finish) begin
                r_cur       <= '0;
                r_base      <= '0;
                r_missed    <= 1'b0;
                r_err       <= ST_OK;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= mode_n;
            r_addr <= rd_addr;
        end
        if (i_cmd.finish) begin
            r_out_found  <= found;
            r_out_status <= r_err;
        end
    end

    assign o_sts.clear_done = (r_clr_cnt == LINK_AW'(LINK_DEPTH - 1));
    assign o_sts.in_go      = walk && letter_ok;
    assign o_sts.in_last    = i_last;
    assign o_sts.item_last  = r_last;
    assign o_sts.out_free   = !r_out_valid || i_ready;

    assign o_valid  = r_out_valid;
    assign o_found  = r_out_found;
    assign o_status = r_out_status;

endmodule

// ----- test/tb_top.sv -----
module tb_top;
    import tsd_pkg::*;

    localparam int NODES       = DEF_NODE_COUNT;
    localparam int ALPHA       = DEF_ALPHABET_SIZE;
    localparam int ITEM_TARGET = 1750;
    localparam int WORD_MAX    = 12;
    localparam int CYCLE_LIMIT = 500000;

    // mode code 3 is not named in the package; the block treats it as a prefix search
    localparam logic [1:0] MODE_ALT_PREFIX = 2'd3;

    typedef logic [WORD_MAX*8-1:0] t_word;

    typedef struct packed {
        logic       found;
        logic [1:0] status;
    } t_answer;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] letter;
        logic       has_letter;
        logic       last;
        logic       typed;
        logic       found;
        logic [1:0] status;
    } t_row;

    localparam int DIR_N = 25;
    localparam t_row DIR_ROWS [0:DIR_N-1] = '{
        '{MODE_EXACT,      8'h00, 1'b0, 1'b1, 1'b1, 1'b0, ST_OK},
        '{MODE_PREFIX,     8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, ST_OK},
        '{MODE_INSERT,     8'h00, 1'b0, 1'b1, 1'b1, 1'b1, ST_OK},
        '{MODE_EXACT,      8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, ST_OK},
        '{MODE_INSERT,     "a",   1'b1, 1'b1, 1'b1, 1'b1, ST_OK},
        '{MODE_INSERT,     "z",   1'b1, 1'b1, 1'b1, 1'b1, ST_OK},
        '{MODE_INSERT,     "a",   1'b1, 1'b0, 1'b0, 1'b0, ST_OK},
        '{MODE_INSERT,     "z",   1'b1, 1'b1, 1'b1, 1'b1, ST_OK},
        '{MODE_EXACT,      "a",   1'b1, 1'b0, 1'b0, 1'b0, ST_OK},
        '{MODE_EXACT,      "z",   1'b1, 1'b1, 1'b0, 1'b0, ST_OK},
        '{MODE_PREFIX,     "q",   1'b1, 1'b1, 1'b0, 1'b0, ST_OK},
        '{MODE_ALT_PREFIX, "a",   1'b1, 1'b1, 1'b0, 1'b0, ST_OK},
        '{MODE_EXACT,      8'h60, 1'b1, 1'b1, 1'b1, 1'b0, ST_BADCHAR},
        '{MODE_PREFIX,     8'h7B, 1'b1, 1'b1, 1'b1, 1'b0, ST_BADCHAR},
        '{MODE_INSERT,     8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK},
        '{MODE_INSERT,     "a",   1'b1, 1'b1, 1'b1, 1'b0, ST_BADCHAR},
        '{MODE_EXACT,      8'h00, 1'b1, 1'b1, 1'b1, 1'b0, ST_BADCHAR},
        '{MODE_EXACT,      "a",   1'b1, 1'b0, 1'b0, 1'b0, ST_OK},
        '{MODE_EXACT,      8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK},
        '{MODE_EXACT,      "z",   1'b1, 1'b1, 1'b0, 1'b0, ST_OK},
        '{MODE_EXACT,      "q",   1'b1, 1'b0, 1'b0, 1'b0, ST_OK},
        '{MODE_INSERT,     "a",   1'b1, 1'b1, 1'b0, 1'b0, ST_OK},
        '{MODE_PREFIX,     "b",   1'b1, 1'b1, 1'b0, 1'b0, ST_OK},
        '{MODE_INSERT,     "b",   1'b1, 1'b0, 1'b0, 1'b0, ST_OK},
        '{MODE_EXACT,      "z",   1'b1, 1'b1, 1'b0, 1'b0, ST_OK}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_mode = MODE_INSERT;
    logic [7:0] i_letter = 8'h00;
    logic       i_has_letter = 1'b0;
    logic       i_last = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic       o_found;
    logic [1:0] o_status;

    trie_string_dictionary u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_letter     (i_letter),
        .i_has_letter (i_has_letter),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_found      (o_found),
        .o_status     (o_status)
    );

    // trie mirror
    int unsigned trie_links [NODES*ALPHA];
    bit          word_end [NODES];
    int unsigned free_node = 1;
    int unsigned cur_node = 0;
    bit          walk_missed = 1'b0;
    logic [1:0]  walk_err = ST_OK;

    t_answer answer_q [$];
    t_word   word_q [$];
    int      wlen_q [$];

    // typed expectation that travels with the item on the bus
    logic       row_typed = 1'b0;
    t_answer    row_answer = '0;

    bit gaps_on = 1'b1;
    int n_items = 0;
    int errors = 0;
    int cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void trie_step(input logic [1:0] mode, input logic [7:0] letter,
                                      input logic has, input logic last_i,
                                      output bit emit, output t_answer ans);
        logic [1:0] m;
        int         sym;
        int         slot;
        m = (mode == MODE_ALT_PREFIX) ? MODE_PREFIX : mode;
        emit = 1'b0;
        ans = '0;
        if (has && walk_err == ST_OK && !walk_missed) begin
            sym = int'(letter) - int'(FIRST_LETTER);
            if (sym < 0 || sym >= ALPHA) begin
                walk_err = ST_BADCHAR;
            end else begin
                slot = cur_node * ALPHA + sym;
                if (m == MODE_INSERT) begin
                    if (trie_links[slot] == 0) begin
                        if (free_node >= NODES) begin
                            walk_err = ST_FULL;
                        end else begin
                            trie_links[slot] = free_node;
                            cur_node = free_node;
                            free_node++;
                        end
                    end else begin
                        cur_node = trie_links[slot];
                    end
                end else if (trie_links[slot] == 0) begin
                    walk_missed = 1'b1;
                end else begin
                    cur_node = trie_links[slot];
                end
            end
        end
        if (last_i) begin
            emit = 1'b1;
            ans.status = walk_err;
            if (walk_err == ST_OK) begin
                case (m)
                    MODE_INSERT: begin
                        if (!walk_missed) begin
                            word_end[cur_node] = 1'b1;
                            ans.found = 1'b1;
                        end
                    end
                    MODE_EXACT: ans.found = !walk_missed && word_end[cur_node];
                    default:    ans.found = !walk_missed;
                endcase
            end
            cur_node = 0;
            walk_missed = 1'b0;
            walk_err = ST_OK;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        bit      emit;
        t_answer ans;
        t_answer got;
        t_answer want;
        if (i_rst_n && i_valid && o_ready) begin
            trie_step(i_mode, i_letter, i_has_letter, i_last, emit, ans);
            if (emit) answer_q.push_back(row_typed ? row_answer : ans);
        end
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_found, o_status};
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result found %0b status %0d", $time,
                         o_found, o_status);
                errors++;
            end else begin
                want = answer_q.pop_front();
                if (got.found !== want.found) begin
                    $display("%0t: found expected %0b got %0b", $time, want.found, got.found);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time,
                             want.status, got.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("** trie_string_dictionary: FAILED **");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= !(gaps_on && $urandom_range(99) < 11);
    end

    task automatic send_item(input logic [1:0] mode, input logic [7:0] letter,
                             input logic has, input logic last_i,
                             input logic typed, input t_answer ans);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 11) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_letter     <= letter;
        i_has_letter <= has;
        i_last       <= last_i;
        row_typed    <= typed;
        row_answer   <= ans;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (has || last_i) n_items++;
    endtask

    function automatic logic [7:0] bad_letter();
        logic [7:0] ch;
        ch = 8'($urandom);
        while (ch >= FIRST_LETTER && ch < FIRST_LETTER + 8'(ALPHA)) ch = 8'($urandom);
        return ch;
    endfunction

    // one string: mostly well formed, with some bad letters, mixed modes and
    // ignored filler items; fill mode gives max_len letters, the string mode insert
    task automatic send_random_string(input int alpha_n, input int max_len, input bit fill);
        logic [1:0] mode;
        logic [1:0] m_i;
        logic [7:0] ch;
        t_word      w;
        int         len;
        int         pick;
        int         k;
        int         r;
        bit         clean;
        pick = $urandom_range(99);
        if (fill)           mode = MODE_INSERT;
        else if (pick < 40) mode = MODE_INSERT;
        else if (pick < 70) mode = MODE_EXACT;
        else if (pick < 95) mode = MODE_PREFIX;
        else                mode = MODE_ALT_PREFIX;
        if (!fill && mode != MODE_INSERT && word_q.size() > 0 && $urandom_range(99) < 60) begin
            k = $urandom_range(word_q.size() - 1);
            w = word_q[k];
            len = wlen_q[k];
            if (len > 0 && $urandom_range(3) == 0) len = $urandom_range(len);
        end else begin
            if (fill) len = max_len;
            else len = ($urandom_range(99) < 4) ? 0 : $urandom_range(max_len, 1);
            w = '0;
            for (int i = 0; i < len; i++) begin
                w[i*8 +: 8] = FIRST_LETTER + 8'($urandom_range(alpha_n - 1));
            end
        end
        clean = 1'b1;
        for (int i = 0; i < len; i++) begin
            ch = w[i*8 +: 8];
            m_i = mode;
            r = $urandom_range(99);
            if (r < 3) begin
                ch = bad_letter();
                clean = 1'b0;
            end else if (r < 6) begin
                m_i = 2'($urandom_range(3));
                clean = 1'b0;
            end
            if ($urandom_range(99) < 4) begin
                send_item(2'($urandom_range(3)), 8'($urandom), 1'b0, 1'b0, 1'b0, '0);
            end
            send_item(m_i, ch, 1'b1, i == len - 1, 1'b0, '0);
        end
        if (len == 0) send_item(mode, 8'($urandom), 1'b0, 1'b1, 1'b0, '0);
        if (mode == MODE_INSERT && clean && len > 0) begin
            if (word_q.size() >= 256) begin
                void'(word_q.pop_front());
                void'(wlen_q.pop_front());
            end
            word_q.push_back(w);
            wlen_q.push_back(len);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_N; r++) begin
            send_item(DIR_ROWS[r].mode, DIR_ROWS[r].letter, DIR_ROWS[r].has_letter,
                      DIR_ROWS[r].last, DIR_ROWS[r].typed,
                      '{DIR_ROWS[r].found, DIR_ROWS[r].status});
        end

        // dense small alphabet so searches hit, with a stall-free stretch
        while (n_items < 800) begin
            gaps_on = !(n_items >= 300 && n_items < 550);
            send_random_string(($urandom_range(9) == 0) ? ALPHA : 4, 6, 1'b0);
        end
        gaps_on = 1'b1;

        // use up the node pool
        while (free_node < NODES) send_random_string(ALPHA, 8, 1'b0 | 1'b1);

        // pool full: inserts that need a node now fail
        for (int s = 0; s < 60 || n_items < ITEM_TARGET; s++) begin
            send_random_string(($urandom_range(3) == 0) ? ALPHA : 4, 6, 1'b0);
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("** trie_string_dictionary: PASSED **");
        end else begin
            $display("** trie_string_dictionary: FAILED **");
        end
        $finish;
    end

endmodule
